[hw/rtl/ldsw_pkg.sv]
// Shared types, command codes and byte constants for the display digit writer.
package ldsw_pkg;

  localparam logic CmdShow = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic CfgBrightness  = 1'b0;
  localparam logic CfgPointEnable = 1'b1;

  localparam logic [7:0] ByteFixedAddr = 8'h44;
  localparam logic [7:0] ByteAddrBase  = 8'hC0;
  localparam logic [7:0] ByteDispCtrl  = 8'h88;
  localparam logic [7:0] SegPoint      = 8'h80;

  // One classified input beat as it travels through the queue.
  typedef struct packed {
    logic       is_tick;
    logic [1:0] position;
    logic [7:0] segments;
    logic       dio_in;
  } item_t;

  // One result beat as produced by the sequencer.
  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy;
    logic ack_timeout;
    logic sequence_done;
  } result_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit, input logic blank,
                                            input logic point);
    logic [7:0] seg;
    seg = 8'h00;
    if (!blank) begin
      case (digit)
        4'd0:    seg = 8'h3F;
        4'd1:    seg = 8'h06;
        4'd2:    seg = 8'h5B;
        4'd3:    seg = 8'h4F;
        4'd4:    seg = 8'h66;
        4'd5:    seg = 8'h6D;
        4'd6:    seg = 8'h7D;
        4'd7:    seg = 8'h07;
        4'd8:    seg = 8'h7F;
        4'd9:    seg = 8'h6F;
        default: seg = 8'h00;
      endcase
    end
    if (point) begin
      seg = seg | SegPoint;
    end
    return seg;
  endfunction

endpackage

[hw/rtl/ldsw_front.sv]
// Front end: classifies an input beat and encodes a digit to segment form.
module ldsw_front (
  input  logic                command_i,
  input  logic [1:0]          position_i,
  input  logic [3:0]          digit_i,
  input  logic                blank_i,
  input  logic                dio_in_i,
  input  logic                point_enable_i,
  output ldsw_pkg::item_t     item_o
);

  always_comb begin
    item_o.is_tick  = (command_i == ldsw_pkg::CmdTick);
    item_o.position = position_i;
    item_o.segments = ldsw_pkg::seg_encode(digit_i, blank_i, point_enable_i);
    item_o.dio_in   = dio_in_i;
  end

endmodule

[hw/rtl/ldsw_queue.sv]
// Two-entry queue that decouples the front end from the pin sequencer.
module ldsw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ldsw_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output ldsw_pkg::item_t pop_item_o
);

  ldsw_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/ldsw_back.sv]
// Back end: pin step sequencer for the three display frames, with result register.
module ldsw_back #(
  parameter int unsigned ACK_LIMIT = 200
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  ldsw_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic [2:0]        brightness_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ldsw_pkg::result_t res_o
);

  localparam int unsigned AckCntW = $clog2(ACK_LIMIT + 1);

  localparam logic [4:0] PhIdle    = 5'd0;
  localparam logic [4:0] PhStartA  = 5'd1;
  localparam logic [4:0] PhStartB  = 5'd2;
  localparam logic [4:0] PhStartC  = 5'd3;
  localparam logic [4:0] PhStartD  = 5'd4;
  localparam logic [4:0] PhBitLow  = 5'd5;
  localparam logic [4:0] PhBitData = 5'd6;
  localparam logic [4:0] PhBitHigh = 5'd7;
  localparam logic [4:0] PhAckLow  = 5'd8;
  localparam logic [4:0] PhAckDhi  = 5'd9;
  localparam logic [4:0] PhAckHigh = 5'd10;
  localparam logic [4:0] PhAckRel  = 5'd11;
  localparam logic [4:0] PhAckWait = 5'd12;
  localparam logic [4:0] PhStopA   = 5'd13;
  localparam logic [4:0] PhStopB   = 5'd14;
  localparam logic [4:0] PhStopC   = 5'd15;
  localparam logic [4:0] PhStopD   = 5'd16;

  logic [4:0]         phase_q, phase_d;
  logic [2:0]         frame_q, frame_d;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         shift_q, shift_d;
  logic [AckCntW-1:0] ack_cnt_q, ack_cnt_d;
  logic [AckCntW-1:0] ack_cnt_inc;
  logic [1:0]         pos_q, pos_d;
  logic [7:0]         seg_q, seg_d;
  logic               clk_q, clk_d;
  logic               dio_q, dio_d;
  logic               drv_q, drv_d;
  logic               out_valid_q, out_valid_d;
  ldsw_pkg::result_t  res_q, res_d;
  logic               take, timeout, done;
  logic [2:0]         frame_inc;

  function automatic logic [7:0] byte_sel(input logic [2:0] idx, input logic [1:0] pos,
                                          input logic [7:0] segs, input logic [2:0] bright);
    logic [7:0] b;
    case (idx)
      3'd0:    b = ldsw_pkg::ByteFixedAddr;
      3'd1:    b = ldsw_pkg::ByteAddrBase | {6'd0, pos};
      3'd2:    b = segs;
      3'd3:    b = ldsw_pkg::ByteDispCtrl + {5'd0, bright};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // A show beat never waits on the result side; a tick needs a free result slot.
  assign take        = item_valid_i && (!item_i.is_tick || !out_valid_q || res_ready_i);
  assign item_pop_o  = take;
  assign ack_cnt_inc = ack_cnt_q + AckCntW'(1);
  assign frame_inc   = frame_q + 3'd1;

  always_comb begin
    phase_d   = phase_q;
    frame_d   = frame_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    ack_cnt_d = ack_cnt_q;
    pos_d     = pos_q;
    seg_d     = seg_q;
    clk_d     = clk_q;
    dio_d     = dio_q;
    drv_d     = drv_q;
    timeout   = 1'b0;
    done      = 1'b0;

    if (take && !item_i.is_tick) begin
      if (phase_q == PhIdle) begin
        pos_d   = item_i.position;
        seg_d   = item_i.segments;
        frame_d = 3'd0;
        phase_d = PhStartA;
      end
    end else if (take) begin
      case (phase_q)
        PhIdle:   phase_d = PhIdle;
        PhStartA: begin clk_d = 1'b1; phase_d = PhStartB; end
        PhStartB: begin dio_d = 1'b1; phase_d = PhStartC; end
        PhStartC: begin dio_d = 1'b0; phase_d = PhStartD; end
        PhStartD: begin
          clk_d   = 1'b0;
          shift_d = byte_sel(frame_q, pos_q, seg_q, brightness_i);
          bit_d   = 3'd0;
          phase_d = PhBitLow;
        end
        PhBitLow: begin clk_d = 1'b0; phase_d = PhBitData; end
        PhBitData: begin
          dio_d   = shift_q[0];
          shift_d = {1'b0, shift_q[7:1]};
          phase_d = PhBitHigh;
        end
        PhBitHigh: begin
          clk_d = 1'b1;
          if (bit_q == 3'd7) begin
            phase_d = PhAckLow;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PhBitLow;
          end
        end
        PhAckLow:  begin clk_d = 1'b0; phase_d = PhAckDhi; end
        PhAckDhi:  begin dio_d = 1'b1; phase_d = PhAckHigh; end
        PhAckHigh: begin clk_d = 1'b1; phase_d = PhAckRel; end
        PhAckRel: begin
          drv_d     = 1'b0;
          ack_cnt_d = '0;
          phase_d   = PhAckWait;
        end
        PhAckWait: begin
          if (!item_i.dio_in || (ack_cnt_inc >= AckCntW'(ACK_LIMIT))) begin
            drv_d     = 1'b1;
            ack_cnt_d = '0;
            if (item_i.dio_in) begin
              // No acknowledge in time: pull the line low ourselves.
              dio_d   = 1'b0;
              timeout = 1'b1;
            end
            frame_d = frame_inc;
            // The address byte runs straight into the segment byte.
            if (frame_inc == 3'd2) begin
              shift_d = byte_sel(frame_inc, pos_q, seg_q, brightness_i);
              bit_d   = 3'd0;
              phase_d = PhBitLow;
            end else begin
              phase_d = PhStopA;
            end
          end else begin
            ack_cnt_d = ack_cnt_inc;
          end
        end
        PhStopA: begin clk_d = 1'b0; phase_d = PhStopB; end
        PhStopB: begin dio_d = 1'b0; phase_d = PhStopC; end
        PhStopC: begin clk_d = 1'b1; phase_d = PhStopD; end
        PhStopD: begin
          dio_d = 1'b1;
          if (frame_q >= 3'd4) begin
            frame_d = 3'd0;
            phase_d = PhIdle;
            done    = 1'b1;
          end else begin
            phase_d = PhStartA;
          end
        end
        default: phase_d = PhIdle;
      endcase
    end

    res_d.clk_level     = clk_d;
    res_d.dio_level     = dio_d;
    res_d.dio_drive     = drv_d;
    res_d.busy          = (phase_d != PhIdle);
    res_d.ack_timeout   = timeout;
    res_d.sequence_done = done;

    if (take && item_i.is_tick) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      frame_q     <= 3'd0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      ack_cnt_q   <= '0;
      pos_q       <= 2'd0;
      seg_q       <= 8'd0;
      clk_q       <= 1'b1;
      dio_q       <= 1'b1;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_q     <= frame_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      ack_cnt_q   <= ack_cnt_d;
      pos_q       <= pos_d;
      seg_q       <= seg_d;
      clk_q       <= clk_d;
      dio_q       <= dio_d;
      drv_q       <= drv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.is_tick) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/led_display_digit_serial_writer.sv]
// Top level of the display digit writer: config registers, front end, queue, sequencer.
// A tick beat passes through the queue, then the result register, to its result beat.
// Throughput: one beat per cycle, set by the single-step sequencer and the two-entry queue,
// unless a tick waits on a full, unread result register. A show beat yields no result and
// never waits on the result side. Reset is asynchronous and active low: sequencer idle,
// pins high and driven, brightness 2, point enabled, queue and result register empty.
module led_display_digit_serial_writer #(
  parameter int unsigned ACK_LIMIT = 200
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [1:0] position_i,
  input  logic [3:0] digit_i,
  input  logic       blank_i,
  input  logic       dio_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       clk_level_o,
  output logic       dio_level_o,
  output logic       dio_drive_o,
  output logic       busy_res_o,
  output logic       ack_timeout_o,
  output logic       sequence_done_o
);

  logic [2:0]        brightness_q;
  logic              point_enable_q;
  ldsw_pkg::item_t   front_item;
  ldsw_pkg::item_t   queue_item;
  logic              queue_valid;
  logic              queue_pop;
  ldsw_pkg::result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q   <= 3'd2;
      point_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ldsw_pkg::CfgBrightness:  brightness_q   <= cfg_data_i;
        ldsw_pkg::CfgPointEnable: point_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ldsw_front u_front (
    .command_i      (command_i),
    .position_i     (position_i),
    .digit_i        (digit_i),
    .blank_i        (blank_i),
    .dio_in_i       (dio_in_i),
    .point_enable_i (point_enable_q),
    .item_o         (front_item)
  );

  ldsw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop),
    .pop_item_o   (queue_item)
  );

  ldsw_back #(
    .ACK_LIMIT (ACK_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .brightness_i (brightness_q),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (result)
  );

  assign clk_level_o     = result.clk_level;
  assign dio_level_o     = result.dio_level;
  assign dio_drive_o     = result.dio_drive;
  assign busy_res_o      = result.busy;
  assign ack_timeout_o   = result.ack_timeout;
  assign sequence_done_o = result.sequence_done;

  // A forced acknowledge always leaves the line driven low in mid-sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_timeout_o |-> dio_drive_o && !dio_level_o && busy_res_o)
    else $error("timeout beat with wrong pin state");

  // Whenever the sequencer is idle the bus rests with both lines high and driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> clk_level_o && dio_level_o && dio_drive_o)
    else $error("idle beat with bus not at rest");

  // The closing step of a sequence leaves the sequencer idle and never times out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sequence_done_o |-> !busy_res_o && !ack_timeout_o)
    else $error("done beat while still busy");

endmodule

[test/tb_led_display_digit_serial_writer.sv]
// Self-checking testbench for the two-wire display digit writer: stimulus, pin-step predictor, checks.
module tb_led_display_digit_serial_writer;

  localparam int AckLimit     = 200;
  localparam int SettleCycles = 10;
  localparam int StallLimit   = 1000;

  // Segment patterns for the digits nine down to zero.
  localparam logic [79:0] SegTable = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                      8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  typedef enum logic [4:0] {
    PhIdle, PhStartA, PhStartB, PhStartC, PhStartD,
    PhBitLow, PhBitData, PhBitHigh,
    PhAckLow, PhAckDhi, PhAckHigh, PhAckRel, PhAckWait,
    PhStopA, PhStopB, PhStopC, PhStopD
  } wire_phase_e;

  typedef struct packed {
    logic       command;
    logic [1:0] position;
    logic [3:0] digit;
    logic       blank;
    logic       dio_in;
  } panel_beat_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we     = 1'b0;
  logic       cfg_index  = 1'b0;
  logic [2:0] cfg_data   = 3'd0;
  logic       in_valid   = 1'b0;
  logic       command    = 1'b0;
  logic [1:0] position   = 2'd0;
  logic [3:0] digit      = 4'd0;
  logic       blank      = 1'b0;
  logic       dio_in     = 1'b0;
  logic       out_ready  = 1'b1;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       clk_level_o;
  logic       dio_level_o;
  logic       dio_drive_o;
  logic       busy_res_o;
  logic       ack_timeout_o;
  logic       sequence_done_o;

  led_display_digit_serial_writer #(
    .ACK_LIMIT(AckLimit)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .command_i      (command),
    .position_i     (position),
    .digit_i        (digit),
    .blank_i        (blank),
    .dio_in_i       (dio_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .clk_level_o    (clk_level_o),
    .dio_level_o    (dio_level_o),
    .dio_drive_o    (dio_drive_o),
    .busy_res_o     (busy_res_o),
    .ack_timeout_o  (ack_timeout_o),
    .sequence_done_o(sequence_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  panel_beat_t       panel_beats_todo[$];
  ldsw_pkg::result_t pin_steps_due[$];
  int                beats_queued   = 0;
  int                beats_accepted = 0;
  int                err_count      = 0;
  int                idle_cycles    = 0;
  logic              in_taken       = 1'b0;

  // Predictor state, reset values as after reset.
  wire_phase_e m_phase  = PhIdle;
  logic [2:0]  m_frame  = 3'd0;
  logic [2:0]  m_bit    = 3'd0;
  logic [7:0]  m_shift  = 8'd0;
  logic [7:0]  m_wait   = 8'd0;
  logic [1:0]  m_pos    = 2'd0;
  logic [7:0]  m_seg    = 8'd0;
  logic        m_clk    = 1'b1;
  logic        m_dio    = 1'b1;
  logic        m_drive  = 1'b1;
  logic [2:0]  m_bright = 3'd2;
  logic        m_point  = 1'b1;

  task automatic load_frame_byte();
    case (m_frame)
      3'd0:    m_shift = ldsw_pkg::ByteFixedAddr;
      3'd1:    m_shift = ldsw_pkg::ByteAddrBase | {6'd0, m_pos};
      3'd2:    m_shift = m_seg;
      3'd3:    m_shift = ldsw_pkg::ByteDispCtrl + {5'd0, m_bright};
      default: m_shift = 8'd0;
    endcase
    m_bit   = 3'd0;
    m_phase = PhBitLow;
  endtask

  // The address frame carries two bytes back to back; every other byte ends in a stop.
  task automatic close_frame_byte();
    m_frame = m_frame + 3'd1;
    if (m_frame == 3'd2) begin
      load_frame_byte();
    end else begin
      m_phase = PhStopA;
    end
  endtask

  task automatic advance_display_model(input panel_beat_t b);
    ldsw_pkg::result_t r;
    logic              timed_out;
    logic              finished;
    timed_out = 1'b0;
    finished  = 1'b0;
    if (b.command == ldsw_pkg::CmdShow) begin
      if (m_phase == PhIdle) begin
        m_seg = (!b.blank && b.digit < 4'd10) ? SegTable[{b.digit, 3'b000} +: 8] : 8'h00;
        if (m_point) begin
          m_seg = m_seg | ldsw_pkg::SegPoint;
        end
        m_pos   = b.position;
        m_frame = 3'd0;
        m_phase = PhStartA;
      end
    end else begin
      case (m_phase)
        PhStartA: begin m_clk = 1'b1; m_phase = PhStartB; end
        PhStartB: begin m_dio = 1'b1; m_phase = PhStartC; end
        PhStartC: begin m_dio = 1'b0; m_phase = PhStartD; end
        PhStartD: begin m_clk = 1'b0; load_frame_byte(); end
        PhBitLow: begin m_clk = 1'b0; m_phase = PhBitData; end
        PhBitData: begin
          m_dio   = m_shift[0];
          m_shift = m_shift >> 1;
          m_phase = PhBitHigh;
        end
        PhBitHigh: begin
          m_clk = 1'b1;
          if (m_bit >= 3'd7) begin
            m_phase = PhAckLow;
          end else begin
            m_bit   = m_bit + 3'd1;
            m_phase = PhBitLow;
          end
        end
        PhAckLow:  begin m_clk = 1'b0; m_phase = PhAckDhi; end
        PhAckDhi:  begin m_dio = 1'b1; m_phase = PhAckHigh; end
        PhAckHigh: begin m_clk = 1'b1; m_phase = PhAckRel; end
        PhAckRel: begin
          m_drive = 1'b0;
          m_wait  = 8'd0;
          m_phase = PhAckWait;
        end
        PhAckWait: begin
          if (!b.dio_in) begin
            m_drive = 1'b1;
            m_wait  = 8'd0;
            close_frame_byte();
          end else begin
            m_wait = m_wait + 8'd1;
            if (m_wait >= AckLimit) begin
              m_drive   = 1'b1;
              m_dio     = 1'b0;
              m_wait    = 8'd0;
              timed_out = 1'b1;
              close_frame_byte();
            end
          end
        end
        PhStopA: begin m_clk = 1'b0; m_phase = PhStopB; end
        PhStopB: begin m_dio = 1'b0; m_phase = PhStopC; end
        PhStopC: begin m_clk = 1'b1; m_phase = PhStopD; end
        PhStopD: begin
          m_dio = 1'b1;
          if (m_frame >= 3'd4) begin
            m_frame  = 3'd0;
            m_phase  = PhIdle;
            finished = 1'b1;
          end else begin
            m_phase = PhStartA;
          end
        end
        default: m_phase = PhIdle;
      endcase
      r.clk_level     = m_clk;
      r.dio_level     = m_dio;
      r.dio_drive     = m_drive;
      r.busy          = (m_phase != PhIdle);
      r.ack_timeout   = timed_out;
      r.sequence_done = finished;
      pin_steps_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      err_count++;
    end
  endtask

  // Input driver: bursts of beats separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;
  always @(negedge clk_i) begin
    panel_beat_t b;
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (panel_beats_todo.size() != 0) begin
          b = panel_beats_todo.pop_front();
          command  <= b.command;
          position <= b.position;
          digit    <= b.digit;
          blank    <= b.blank;
          dio_in   <= b.dio_in;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stalls follow a 16-bit mask, stepped by a 6-bit phase counter and redrawn when it wraps.
  logic [15:0] ready_mask  = 16'hFFFF;
  logic [5:0]  ready_phase = 6'd0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (ready_phase == 6'd0) begin
        if ($urandom_range(0, 3) == 0) begin
          ready_mask = 16'hFFFF;
        end else begin
          ready_mask    = 16'($urandom);
          ready_mask[0] = 1'b1;
        end
      end
      out_ready   <= ready_mask[ready_phase[3:0]];
      ready_phase = ready_phase + 6'd1;
    end
  end

  // Monitor: checks each result beat against the oldest expectation, then predicts new ones.
  always @(posedge clk_i) begin
    panel_beat_t       b;
    ldsw_pkg::result_t want;
    if (rst_ni) begin
      in_taken <= in_valid && in_ready_o;
      if (out_valid_o && out_ready) begin
        if (pin_steps_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          err_count++;
        end else begin
          want = pin_steps_due.pop_front();
          check_field("clk_level", want.clk_level, clk_level_o);
          check_field("dio_level", want.dio_level, dio_level_o);
          check_field("dio_drive", want.dio_drive, dio_drive_o);
          check_field("busy_res", want.busy, busy_res_o);
          check_field("ack_timeout", want.ack_timeout, ack_timeout_o);
          check_field("sequence_done", want.sequence_done, sequence_done_o);
        end
      end
      if (in_valid && in_ready_o) begin
        b = '{command, position, digit, blank, dio_in};
        advance_display_model(b);
        beats_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid && in_ready_o) || (out_valid_o && out_ready))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_led_display_digit_serial_writer failed");
      $finish;
    end
  end

  task automatic queue_beat(input logic cmd, input logic [1:0] pos, input logic [3:0] dig,
                            input logic blk, input logic dio);
    panel_beats_todo.push_back('{cmd, pos, dig, blk, dio});
    beats_queued++;
  endtask

  task automatic wait_drained();
    while (beats_accepted != beats_queued || pin_steps_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Ticks with a prompt acknowledge until the predicted sequencer is idle again.
  task automatic settle_to_idle();
    wait_drained();
    while (m_phase != PhIdle) begin
      repeat (16) queue_beat(ldsw_pkg::CmdTick, 2'd0, 4'd0, 1'b0, 1'b0);
      wait_drained();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ldsw_pkg::CfgBrightness) begin
      m_bright = data;
    end else begin
      m_point = data[0];
    end
  endtask

  task automatic set_config(input logic [2:0] bright, input logic point);
    write_reg(ldsw_pkg::CfgBrightness, bright);
    write_reg(ldsw_pkg::CfgPointEnable, {2'($urandom_range(0, 3)), point});
  endtask

  task automatic run_random_phase(input int count);
    int r;
    int run;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        queue_beat(ldsw_pkg::CmdShow, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
      end else if (r < 14) begin
        // A run of high samples holds the acknowledge wait open for a while.
        run = $urandom_range(6, 20);
        repeat (run) queue_beat(ldsw_pkg::CmdTick, 2'($urandom_range(0, 3)),
                                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b1);
        i += run - 1;
      end else begin
        queue_beat(ldsw_pkg::CmdTick, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 45));
      end
    end
    settle_to_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the reset configuration.
    queue_beat(ldsw_pkg::CmdTick, 2'd0, 4'd0, 1'b0, 1'b1);
    queue_beat(ldsw_pkg::CmdTick, 2'd3, 4'd15, 1'b1, 1'b0);
    queue_beat(ldsw_pkg::CmdShow, 2'd0, 4'd0, 1'b0, 1'b0);
    queue_beat(ldsw_pkg::CmdShow, 2'd3, 4'd9, 1'b1, 1'b1);
    repeat (32) queue_beat(ldsw_pkg::CmdTick, 2'd1, 4'd7, 1'b0, 1'b0);
    // A few high samples before the acknowledge arrives.
    repeat (5) queue_beat(ldsw_pkg::CmdTick, 2'd0, 4'd0, 1'b0, 1'b1);
    settle_to_idle();

    // Acknowledge timeout on the first byte, with a digit above nine and no point.
    set_config(3'd7, 1'b0);
    queue_beat(ldsw_pkg::CmdShow, 2'd2, 4'd12, 1'b0, 1'b1);
    repeat (32 + AckLimit) queue_beat(ldsw_pkg::CmdTick, 2'd0, 4'd0, 1'b0, 1'b1);
    settle_to_idle();

    set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    run_random_phase(100);

    if (err_count == 0 && pin_steps_due.size() == 0) begin
      $display("tb_led_display_digit_serial_writer passed");
    end else begin
      $display("tb_led_display_digit_serial_writer failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ldsw_pkg.sv
hw/rtl/ldsw_front.sv
hw/rtl/ldsw_queue.sv
hw/rtl/ldsw_back.sv
hw/rtl/led_display_digit_serial_writer.sv
test/tb_led_display_digit_serial_writer.sv
